// ----- rtl/spa_pkg.sv -----
// shared types, constants and saturating helpers for the sgm path cost aggregation block
// no dependencies; imported by spa_cost_calc, sgm_path_cost_aggregation and spa_checker
package spa_pkg;

    localparam int COST_W = 8;
    localparam int DISP_OUT_W = 6;
    localparam int CFG_IDX_W = 1;

    typedef logic [COST_W-1:0] t_cost;

    localparam t_cost COST_SAT = t_cost'(255);
    localparam t_cost RST_SMALL_PENALTY = t_cost'(10);
    localparam t_cost RST_LARGE_PENALTY = t_cost'(120);
    localparam t_cost RST_PREV_MIN = t_cost'(0);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMALL_PENALTY = 1'b0,
        CFG_LARGE_PENALTY = 1'b1
    } t_cfg_idx;

    // operands of one path cost evaluation
    typedef struct packed {
        logic  path_start;
        logic  first;
        logic  last;
        t_cost match_cost;
        t_cost here;
        t_cost lower;
        t_cost upper;
        t_cost prev_min;
        t_cost small_penalty;
        t_cost large_penalty;
    } t_calc_in;

    // a + b clipped at the cost maximum
    function automatic t_cost sat_add(input t_cost a, input t_cost b);
        logic [COST_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[COST_W] ? COST_SAT : sum[COST_W-1:0];
    endfunction

    function automatic t_cost min_cost(input t_cost a, input t_cost b);
        return (a < b) ? a : b;
    endfunction

endpackage

// ----- rtl/spa_ram.sv -----
// generic simple dual port ram: one write port, one read port with registered read data
// no dependencies
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/spa_cost_calc.sv -----
// path cost evaluation for one disparity: penalised neighbour terms, minimum, normalization
// depends on spa_pkg
module spa_cost_calc
    import spa_pkg::*;
(
    input  t_calc_in i_calc,
    output t_cost    o_path_cost
);

    t_cost lower_term;
    t_cost upper_term;
    t_cost jump_term;
    t_cost best;
    t_cost delta;

    // penalised candidates, edge neighbours count as the maximum
    always_comb begin
        lower_term = i_calc.first ? COST_SAT : sat_add(i_calc.lower, i_calc.small_penalty);
        upper_term = i_calc.last ? COST_SAT : sat_add(i_calc.upper, i_calc.small_penalty);
        jump_term  = sat_add(i_calc.prev_min, i_calc.large_penalty);
        best = min_cost(min_cost(i_calc.here, lower_term), min_cost(upper_term, jump_term));
    end

    // subtract the previous minimum, clipped at zero, then add the match cost
    always_comb begin
        delta = (best >= i_calc.prev_min) ? (best - i_calc.prev_min) : '0;
        o_path_cost = i_calc.path_start ? i_calc.match_cost
                                        : sat_add(i_calc.match_cost, delta);
    end

endmodule

// ----- rtl/sgm_path_cost_aggregation.sv -----
// top level of the sgm path cost aggregation block
// depends on spa_pkg, spa_ram and spa_cost_calc
//
// Takes one matching cost word per clock while the output is not stalled, disparities
// 0 .. NUM_DISP-1 of one pixel after the other, and returns one path cost word per
// input word, in order; a result passes through the evaluation stage register and then
// the output register. The previous pixel's cost vector sits in a NUM_DISP x 8 ram
// with one write per word and one read per word but the last disparity: the read,
// issued as a word is accepted, fetches the entry above it, the entry itself and the
// one below come from registers. The vector needs no clearing after reset; a pixel
// that is not flagged as path start must follow a full pixel. Penalties are to be
// written through the config port by the user while the block is idle, unenforced.
module sgm_path_cost_aggregation
    import spa_pkg::*;
#(
    parameter int NUM_DISP = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COST_W-1:0]    i_cfg_data,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [COST_W-1:0]    i_match_cost,
    input  logic                 i_path_start,
    // output words
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [COST_W-1:0]    o_path_cost,
    output logic [DISP_OUT_W-1:0] o_disparity,
    output logic                 o_pixel_done
);

    localparam int DW = (NUM_DISP > 1) ? $clog2(NUM_DISP) : 1;
    localparam logic [DW-1:0] LAST_D = DW'(NUM_DISP - 1);

    // configuration registers
    t_cost r_small_penalty;
    t_cost r_large_penalty;

    // disparity counter at the input
    logic [DW-1:0] r_cnt;
    logic [DW-1:0] n_cnt;
    logic          in_accept;
    logic          in_last;

    // evaluation stage
    logic          r_s1_valid;
    logic [DW-1:0] r_s1_d;
    logic          r_s1_last;
    t_cost         r_s1_cost;
    logic          r_s1_start;
    logic          s1_move;

    // path state
    t_cost r_lower;
    t_cost r_here_nxt;
    t_cost r_first;
    t_cost r_prev_min;
    t_cost r_run_min;
    t_cost n_run_min;

    // write forwarding into the neighbour read
    logic  r_fwd;
    t_cost r_fwd_data;

    // ram signals
    logic [DW-1:0] ram_raddr;
    logic          ram_re;
    t_cost         ram_rdata;

    // output register
    logic          r_out_valid;
    t_cost         r_out_cost;
    logic [DW-1:0] r_out_disp;
    logic          r_out_done;

    t_calc_in calc;
    t_cost    cur;
    t_cost    here;
    t_cost    upper_raw;

    // handshake
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_accept  = i_in_valid && o_in_ready;
    assign in_last    = (r_cnt == LAST_D);
    assign n_cnt      = in_last ? '0 : r_cnt + DW'(1);

    // fetch the entry above the disparity being accepted
    assign ram_re    = in_accept && !in_last;
    assign ram_raddr = n_cnt;

    spa_ram #(
        .WIDTH (COST_W),
        .DEPTH (NUM_DISP)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s1_move),
        .i_waddr (r_s1_d),
        .i_wdata (cur),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // operand selection for the evaluation stage
    always_comb begin
        upper_raw = r_fwd ? r_fwd_data : ram_rdata;
        here      = (r_s1_d == '0) ? r_first : r_here_nxt;
        calc.path_start    = r_s1_start;
        calc.first         = (r_s1_d == '0);
        calc.last          = r_s1_last;
        calc.match_cost    = r_s1_cost;
        calc.here          = here;
        calc.lower         = r_lower;
        calc.upper         = upper_raw;
        calc.prev_min      = r_prev_min;
        calc.small_penalty = r_small_penalty;
        calc.large_penalty = r_large_penalty;
    end

    spa_cost_calc u_calc (
        .i_calc      (calc),
        .o_path_cost (cur)
    );

    assign n_run_min = min_cost(r_run_min, cur);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_penalty <= RST_SMALL_PENALTY;
            r_large_penalty <= RST_LARGE_PENALTY;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SMALL_PENALTY: r_small_penalty <= i_cfg_data;
                CFG_LARGE_PENALTY: r_large_penalty <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input side control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_cnt <= n_cnt;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // evaluation stage payload and forwarding of a same-edge write
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_d     <= r_cnt;
            r_s1_last  <= in_last;
            r_s1_cost  <= i_match_cost;
            r_s1_start <= i_path_start;
            r_fwd      <= s1_move && (r_s1_d == ram_raddr);
            r_fwd_data <= cur;
        end
    end

    // path state updated as each word leaves the evaluation stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower    <= COST_SAT;
            r_prev_min <= RST_PREV_MIN;
            r_run_min  <= COST_SAT;
        end else if (s1_move) begin
            if (r_s1_last) begin
                r_lower    <= COST_SAT;
                r_prev_min <= n_run_min;
                r_run_min  <= COST_SAT;
            end else begin
                r_lower    <= here;
                r_run_min  <= n_run_min;
            end
        end
    end

    // neighbour values carried to the next disparity
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_here_nxt <= upper_raw;
            if (r_s1_d == '0) begin
                r_first <= cur;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_cost <= cur;
            r_out_disp <= r_s1_d;
            r_out_done <= r_s1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_path_cost  = r_out_cost;
    assign o_disparity  = DISP_OUT_W'(r_out_disp);
    assign o_pixel_done = r_out_done;

endmodule

// ----- rtl/spa_checker.sv -----
// port level checks for the sgm path cost aggregation block, bound to its top level
// depends on spa_pkg and sgm_path_cost_aggregation
module spa_checker
    import spa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [COST_W-1:0]     o_path_cost,
    input logic [DISP_OUT_W-1:0] o_disparity,
    input logic                  o_pixel_done
);

    logic                  in_acc;
    logic                  out_acc;
    logic [1:0]            r_pending;
    logic [DISP_OUT_W-1:0] r_exp_disp;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(in_acc) - 2'(out_acc);
        end
    end

    // disparity expected on the next delivered word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_disp <= '0;
        end else if (out_acc) begin
            r_exp_disp <= o_pixel_done ? '0 : o_disparity + DISP_OUT_W'(1);
        end
    end

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_path_cost)
            && $stable(o_disparity) && $stable(o_pixel_done))
        else $error("output word changed while stalled");

    // disparities run in order and restart after the last of a pixel
    a_disp_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> o_disparity == r_exp_disp)
        else $error("disparity out of sequence");

    // every result stems from an accepted word, at most two in flight
    a_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid |-> r_pending != 2'd0) and (r_pending != 2'd3))
        else $error("result count does not match accepted words");

    // input stalls only behind a full, stalled output
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled with output free");

endmodule

bind sgm_path_cost_aggregation spa_checker u_spa_checker (.*);
